### rtl/rpnc_pkg.sv
`default_nettype none

package rpnc_pkg;

    // Value format: signed Q16.16.
    localparam int VALUE_W = 32;
    localparam int FRAC_W  = 16;

    // Field widths of the channels.
    localparam int CMD_W    = 4;
    localparam int STATUS_W = 3;
    localparam int DEPTH_OUT_W = 8;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH  = 4'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_SUB   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_MUL   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_DIV   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_POP   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_PEEK  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_DUP   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_SWAP  = 4'd8;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 4'd9;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ZDIV  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SAT   = 3'd4;

    // Iteration counts of the shared unit.
    localparam int MUL_STEPS = VALUE_W;
    localparam int DIV_STEPS = VALUE_W + FRAC_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    // Operation of the shared arithmetic unit.
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic sat_hit;
    } t_alu_rsp;

endpackage

`default_nettype wire

### rtl/rpnc_cmd_if.sv
`default_nettype none

interface rpnc_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [rpnc_pkg::CMD_W-1:0]          cmd;
    logic signed [rpnc_pkg::VALUE_W-1:0] operand_value;

    modport source (output valid, output cmd, output operand_value, input ready);
    modport sink   (input valid, input cmd, input operand_value, output ready);
endinterface

`default_nettype wire

### rtl/rpnc_res_if.sv
`default_nettype none

interface rpnc_res_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [rpnc_pkg::VALUE_W-1:0]   result_value;
    logic                                  value_valid;
    logic [rpnc_pkg::STATUS_W-1:0]         status;
    logic [rpnc_pkg::DEPTH_OUT_W-1:0]      depth_after;

    modport source (output valid, output result_value, output value_valid,
                    output status, output depth_after, input ready);
    modport sink   (input valid, input result_value, input value_valid,
                    input status, input depth_after, output ready);
endinterface

`default_nettype wire

### rtl/rpnc_stack_ram.sv
`default_nettype none

module rpnc_stack_ram #(
    parameter int  DEPTH  = 128,
    localparam int AddrW  = $clog2(DEPTH)
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_wr_en,
    input  wire logic [AddrW-1:0]                    i_wr_addr,
    input  wire logic [rpnc_pkg::VALUE_W-1:0]        i_wr_data,
    input  wire logic                                i_rd_en,
    input  wire logic [AddrW-1:0]                    i_rd_addr,
    output      logic [rpnc_pkg::VALUE_W-1:0]        o_rd_data
);

    logic [rpnc_pkg::VALUE_W-1:0] r_mem [DEPTH];

    // One write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // One read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/rpnc_alu.sv
`default_nettype none

module rpnc_alu (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire rpnc_pkg::t_alu_req                  i_req,
    input  wire logic signed [rpnc_pkg::VALUE_W-1:0] i_a,
    input  wire logic signed [rpnc_pkg::VALUE_W-1:0] i_b,
    output      rpnc_pkg::t_alu_rsp                  o_rsp,
    output      logic signed [rpnc_pkg::VALUE_W-1:0] o_result
);

    localparam int VW   = rpnc_pkg::VALUE_W;
    localparam int FW   = rpnc_pkg::FRAC_W;
    localparam int HI_W = VW + 1;
    localparam int LO_W = VW + FW;
    localparam int CW   = rpnc_pkg::CNT_W;

    localparam logic [VW-1:0]   VAL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0]   VAL_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic [LO_W-1:0] MAG_MAX = LO_W'(VAL_MAX);
    localparam logic [LO_W-1:0] MAG_MIN = LO_W'(VAL_MIN);

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_STEP = 3'b010,
        U_FIN  = 3'b100
    } t_ustate;

    t_ustate            r_state, n_state;
    rpnc_pkg::t_alu_op  r_op, n_op;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_neg, n_neg;
    logic [HI_W-1:0]    r_hi, n_hi;
    logic [LO_W-1:0]    r_lo, n_lo;
    logic [HI_W-1:0]    r_y, n_y;
    logic               r_done, n_done;
    logic               r_hit, n_hit;
    logic [VW-1:0]      r_res, n_res;

    logic [VW-1:0]   w_mag_a;
    logic [VW-1:0]   w_mag_b;
    logic [HI_W-1:0] w_x;
    logic            w_sub;
    logic [HI_W-1:0] w_sum;
    logic [HI_W-1:0] w_mul_hi;
    logic            w_qbit;
    logic [LO_W-1:0] w_mag;

    // Operand magnitudes for the unsigned multiply and divide iterations.
    assign w_mag_a = i_a[VW-1] ? (~$unsigned(i_a) + 1'b1) : $unsigned(i_a);
    assign w_mag_b = i_b[VW-1] ? (~$unsigned(i_b) + 1'b1) : $unsigned(i_b);

    // The shared adder: add for sums and partial products, subtract for
    // differences and trial subtraction.
    assign w_x   = (r_op == rpnc_pkg::OP_DIV) ? {r_hi[VW-1:0], r_lo[LO_W-1]} : r_hi;
    assign w_sub = (r_op == rpnc_pkg::OP_SUB) || (r_op == rpnc_pkg::OP_DIV);
    assign w_sum = w_x + (w_sub ? ~r_y : r_y) + HI_W'(w_sub);

    assign w_mul_hi = r_lo[0] ? w_sum : r_hi;
    assign w_qbit   = ~w_sum[HI_W-1];

    // Magnitude of the scaled product or quotient.
    assign w_mag = (r_op == rpnc_pkg::OP_MUL) ? {r_hi[VW-1:0], r_lo[VW-1:FW]} : r_lo;

    // Sequencing of the unit.
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_y     = r_y;
        n_done  = 1'b0;
        n_hit   = r_hit;
        n_res   = r_res;
        case (r_state)
            U_IDLE: begin
                if (i_req.start) begin
                    n_op    = i_req.op;
                    n_neg   = i_a[VW-1] ^ i_b[VW-1];
                    n_state = U_STEP;
                    case (i_req.op)
                        rpnc_pkg::OP_MUL: begin
                            n_hi  = '0;
                            n_lo  = LO_W'(w_mag_b);
                            n_y   = HI_W'(w_mag_a);
                            n_cnt = CW'(rpnc_pkg::MUL_STEPS);
                        end
                        rpnc_pkg::OP_DIV: begin
                            n_hi  = '0;
                            n_lo  = {w_mag_a, {FW{1'b0}}};
                            n_y   = HI_W'(w_mag_b);
                            n_cnt = CW'(rpnc_pkg::DIV_STEPS);
                        end
                        default: begin
                            n_hi  = {i_a[VW-1], i_a};
                            n_y   = {i_b[VW-1], i_b};
                            n_cnt = CW'(1);
                        end
                    endcase
                end
            end
            U_STEP: begin
                case (r_op)
                    rpnc_pkg::OP_MUL: begin
                        n_hi = {1'b0, w_mul_hi[HI_W-1:1]};
                        n_lo = {r_lo[LO_W-1:VW], w_mul_hi[0], r_lo[VW-1:1]};
                    end
                    rpnc_pkg::OP_DIV: begin
                        n_hi = w_qbit ? w_sum : w_x;
                        n_lo = {r_lo[LO_W-2:0], w_qbit};
                    end
                    default: begin
                        n_hi = w_sum;
                    end
                endcase
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = U_FIN;
                end
            end
            U_FIN: begin
                // Clamp the result to the value range.
                n_hit = 1'b0;
                if ((r_op == rpnc_pkg::OP_ADD) || (r_op == rpnc_pkg::OP_SUB)) begin
                    if (r_hi[HI_W-1] != r_hi[VW-1]) begin
                        n_hit = 1'b1;
                        n_res = r_hi[HI_W-1] ? VAL_MIN : VAL_MAX;
                    end else begin
                        n_res = r_hi[VW-1:0];
                    end
                end else if (r_neg) begin
                    if (w_mag > MAG_MIN) begin
                        n_hit = 1'b1;
                        n_res = VAL_MIN;
                    end else begin
                        n_res = ~w_mag[VW-1:0] + 1'b1;
                    end
                end else begin
                    if (w_mag > MAG_MAX) begin
                        n_hit = 1'b1;
                        n_res = VAL_MAX;
                    end else begin
                        n_res = w_mag[VW-1:0];
                    end
                end
                n_done  = 1'b1;
                n_state = U_IDLE;
            end
            default: begin
                n_state = U_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
        r_hi  <= n_hi;
        r_lo  <= n_lo;
        r_y   <= n_y;
        r_hit <= n_hit;
        r_res <= n_res;
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.sat_hit = r_hit;
    assign o_result      = $signed(r_res);

endmodule

`default_nettype wire

### rtl/rpn_stack_calculator.sv
`default_nettype none

// Reverse Polish calculator on a stack of signed Q16.16 values held in a
// single-port-write, registered-read memory of STACK_DEPTH entries. Every
// command item yields exactly one result item with the popped, peeked or
// computed value, a status code and the stack depth after the command.
// The block takes one command at a time and holds ready low until that
// command is finished. A finished result waits in an output register, so the
// next command can be taken before the result is drained.
// Push, clear, unknown codes and commands refused on an empty or full stack
// go from dispatch straight to the done state. Pop, peek, dup and a zero
// divisor take one stack read, and swap takes two reads and two writes.
// Arithmetic takes up to two stack reads, the shared unit and one write:
// multiply and divide run bit by bit through one shared 33-bit adder, 32 steps
// for a product and 48 steps for a quotient. Ready returns in the cycle in
// which the result is first offered.
// While the output register still holds an untaken result, a finished
// command waits.
module rpn_stack_calculator #(
    parameter int STACK_DEPTH = 128
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    rpnc_cmd_if.sink      i_cmd,
    rpnc_res_if.source    o_res
);

    localparam int VW      = rpnc_pkg::VALUE_W;
    localparam int ADDR_W  = $clog2(STACK_DEPTH);
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DISP  = 8'b0000_0010,
        S_RDB   = 8'b0000_0100,
        S_RDA   = 8'b0000_1000,
        S_SWAP2 = 8'b0001_0000,
        S_CALC  = 8'b0010_0000,
        S_DONE  = 8'b0100_0000,
        S_HOLD  = 8'b1000_0000
    } t_state;

    t_state                        r_state, n_state;
    logic [DEPTH_W-1:0]            r_depth, n_depth;
    logic                          r_have, n_have;
    logic                          r_under, n_under;
    logic [rpnc_pkg::CMD_W-1:0]    r_cmd, n_cmd;
    logic [VW-1:0]                 r_opnd, n_opnd;
    logic [VW-1:0]                 r_b, n_b;
    logic [VW-1:0]                 r_res_val, n_res_val;
    logic                          r_res_vld, n_res_vld;
    logic [rpnc_pkg::STATUS_W-1:0] r_status, n_status;

    logic                             r_out_valid, n_out_valid;
    logic [VW-1:0]                    r_out_val;
    logic                             r_out_vv;
    logic [rpnc_pkg::STATUS_W-1:0]    r_out_st;
    logic [rpnc_pkg::DEPTH_OUT_W-1:0] r_out_depth;

    logic               w_in_acc;
    logic               w_slot_free;
    logic               w_load_out;
    logic [DEPTH_W-1:0] w_dm1;
    logic [DEPTH_W-1:0] w_dm2;
    logic               w_empty;
    logic               w_full;
    logic               w_lt2;
    logic [VW-1:0]      w_rd_data;
    logic [VW-1:0]      w_opnd_b;
    logic [VW-1:0]      w_opnd_a;

    logic               w_wr_en;
    logic [ADDR_W-1:0]  w_wr_addr;
    logic [VW-1:0]      w_wr_data;
    logic               w_rd_en;
    logic [ADDR_W-1:0]  w_rd_addr;

    rpnc_pkg::t_alu_req         w_req;
    rpnc_pkg::t_alu_rsp         w_rsp;
    logic signed [VW-1:0]       w_alu_res;

    rpnc_stack_ram #(
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    rpnc_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_a      ($signed(w_opnd_a)),
        .i_b      ($signed(r_b)),
        .o_rsp    (w_rsp),
        .o_result (w_alu_res)
    );

    // Handshakes and stack pointer arithmetic.
    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_in_acc    = i_cmd.valid && i_cmd.ready;
    assign w_slot_free = !r_out_valid || o_res.ready;
    assign w_load_out  = (r_state == S_DONE) && w_slot_free;

    assign w_dm1   = r_depth - DEPTH_W'(1);
    assign w_dm2   = r_depth - DEPTH_W'(2);
    assign w_empty = (r_depth == '0);
    assign w_full  = (r_depth == DEPTH_W'(STACK_DEPTH));
    assign w_lt2   = (r_depth < DEPTH_W'(2));

    // A missing operand reads as zero.
    assign w_opnd_b = r_have ? w_rd_data : '0;
    assign w_opnd_a = r_have ? w_rd_data : '0;

    // Command sequencer.
    always_comb begin
        n_state   = r_state;
        n_depth   = r_depth;
        n_have    = r_have;
        n_under   = r_under;
        n_cmd     = r_cmd;
        n_opnd    = r_opnd;
        n_b       = r_b;
        n_res_val = r_res_val;
        n_res_vld = r_res_vld;
        n_status  = r_status;
        w_wr_en   = 1'b0;
        w_wr_addr = r_depth[ADDR_W-1:0];
        w_wr_data = r_opnd;
        w_rd_en   = 1'b0;
        w_rd_addr = w_dm1[ADDR_W-1:0];
        w_req     = '0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_cmd     = i_cmd.cmd;
                    n_opnd    = $unsigned(i_cmd.operand_value);
                    n_res_val = '0;
                    n_res_vld = 1'b0;
                    n_status  = rpnc_pkg::ST_OK;
                    n_under   = 1'b0;
                    n_have    = 1'b0;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                case (r_cmd)
                    rpnc_pkg::CMD_PUSH: begin
                        if (w_full) begin
                            n_status = rpnc_pkg::ST_FULL;
                        end else begin
                            w_wr_en = 1'b1;
                            n_depth = r_depth + DEPTH_W'(1);
                        end
                        n_state = S_DONE;
                    end
                    rpnc_pkg::CMD_ADD, rpnc_pkg::CMD_SUB,
                    rpnc_pkg::CMD_MUL, rpnc_pkg::CMD_DIV: begin
                        // Take the divisor or right-hand operand first.
                        if (w_empty) begin
                            n_under = 1'b1;
                        end else begin
                            w_rd_en = 1'b1;
                            n_depth = w_dm1;
                            n_have  = 1'b1;
                        end
                        n_state = S_RDB;
                    end
                    rpnc_pkg::CMD_POP, rpnc_pkg::CMD_PEEK: begin
                        if (w_empty) begin
                            n_status = rpnc_pkg::ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            w_rd_en = 1'b1;
                            n_state = S_RDB;
                        end
                    end
                    rpnc_pkg::CMD_DUP: begin
                        if (w_empty) begin
                            n_status = rpnc_pkg::ST_EMPTY;
                            n_state  = S_DONE;
                        end else if (w_full) begin
                            n_status = rpnc_pkg::ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            w_rd_en = 1'b1;
                            n_state = S_RDB;
                        end
                    end
                    rpnc_pkg::CMD_SWAP: begin
                        if (w_lt2) begin
                            n_status = rpnc_pkg::ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            w_rd_en = 1'b1;
                            n_state = S_RDB;
                        end
                    end
                    rpnc_pkg::CMD_CLEAR: begin
                        n_depth = '0;
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RDB: begin
                case (r_cmd)
                    rpnc_pkg::CMD_POP, rpnc_pkg::CMD_PEEK: begin
                        n_res_val = w_rd_data;
                        n_res_vld = 1'b1;
                        if (r_cmd == rpnc_pkg::CMD_POP) begin
                            n_depth = w_dm1;
                        end
                        n_state = S_DONE;
                    end
                    rpnc_pkg::CMD_DUP: begin
                        w_wr_en   = 1'b1;
                        w_wr_data = w_rd_data;
                        n_depth   = r_depth + DEPTH_W'(1);
                        n_state   = S_DONE;
                    end
                    rpnc_pkg::CMD_SWAP: begin
                        n_b       = w_rd_data;
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_dm2[ADDR_W-1:0];
                        n_state   = S_RDA;
                    end
                    rpnc_pkg::CMD_ADD, rpnc_pkg::CMD_SUB,
                    rpnc_pkg::CMD_MUL, rpnc_pkg::CMD_DIV: begin
                        n_b = w_opnd_b;
                        if ((r_cmd == rpnc_pkg::CMD_DIV) && (w_opnd_b == '0)) begin
                            // The zero divisor is consumed; the dividend stays.
                            n_status = r_under ? rpnc_pkg::ST_EMPTY : rpnc_pkg::ST_ZDIV;
                            n_state  = S_DONE;
                        end else begin
                            if (w_empty) begin
                                n_under = 1'b1;
                                n_have  = 1'b0;
                            end else begin
                                w_rd_en = 1'b1;
                                n_depth = w_dm1;
                                n_have  = 1'b1;
                            end
                            n_state = S_RDA;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RDA: begin
                if (r_cmd == rpnc_pkg::CMD_SWAP) begin
                    // Second entry goes to the top; the old top follows.
                    w_wr_en   = 1'b1;
                    w_wr_addr = w_dm1[ADDR_W-1:0];
                    w_wr_data = w_rd_data;
                    n_state   = S_SWAP2;
                end else begin
                    w_req.start = 1'b1;
                    case (r_cmd)
                        rpnc_pkg::CMD_SUB: w_req.op = rpnc_pkg::OP_SUB;
                        rpnc_pkg::CMD_MUL: w_req.op = rpnc_pkg::OP_MUL;
                        rpnc_pkg::CMD_DIV: w_req.op = rpnc_pkg::OP_DIV;
                        default:           w_req.op = rpnc_pkg::OP_ADD;
                    endcase
                    n_state = S_CALC;
                end
            end
            S_SWAP2: begin
                w_wr_en   = 1'b1;
                w_wr_addr = w_dm2[ADDR_W-1:0];
                w_wr_data = r_b;
                n_state   = S_DONE;
            end
            S_CALC: begin
                // The result always fits: an entry was taken or the stack was empty.
                if (w_rsp.done) begin
                    w_wr_en   = 1'b1;
                    w_wr_data = $unsigned(w_alu_res);
                    n_depth   = r_depth + DEPTH_W'(1);
                    n_res_val = $unsigned(w_alu_res);
                    if (r_under) begin
                        n_status = rpnc_pkg::ST_EMPTY;
                    end else if (w_rsp.sat_hit) begin
                        n_status = rpnc_pkg::ST_SAT;
                    end else begin
                        n_status = rpnc_pkg::ST_OK;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register valid.
    always_comb begin
        n_out_valid = r_out_valid && !o_res.ready;
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
        end
    end

    // Item payload registers.
    always_ff @(posedge i_clk) begin
        r_have    <= n_have;
        r_under   <= n_under;
        r_cmd     <= n_cmd;
        r_opnd    <= n_opnd;
        r_b       <= n_b;
        r_res_val <= n_res_val;
        r_res_vld <= n_res_vld;
        r_status  <= n_status;
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_val   <= r_res_val;
            r_out_vv    <= r_res_vld;
            r_out_st    <= r_status;
            r_out_depth <= rpnc_pkg::DEPTH_OUT_W'(r_depth);
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.result_value = $signed(r_out_val);
    assign o_res.value_valid  = r_out_vv;
    assign o_res.status       = r_out_st;
    assign o_res.depth_after  = r_out_depth;

`ifndef SYNTH
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_DISP))
        else $error("accepted item not dispatched");

    a_alu_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_CALC))
        else $error("arithmetic unit finished outside the calculate step");

    a_valid_value_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_vv) |-> (r_out_st == rpnc_pkg::ST_OK))
        else $error("delivered value carries a failure status");
`endif

endmodule

`default_nettype wire
